>>> sv/lrc_pkg.sv
// ---------------------------------------------------------------------------
// lrc_pkg
// Shared types, codes and the CRC32C byte table for the log record checker.
// ---------------------------------------------------------------------------
package lrc_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 2048;
  localparam int READ_IDX_W        = 11;
  localparam int CFG_DATA_W        = 10;
  localparam int KEY_LIM_W         = 8;
  localparam int VAL_LIM_W         = 10;
  localparam int HDR_BYTES         = 9;

  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;
  localparam logic [KEY_LIM_W-1:0] KEY_LIM_RST = 8'd255;
  localparam logic [VAL_LIM_W-1:0] VAL_LIM_RST = 10'd1023;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_LIMIT   = 1'b0;
  localparam cfg_idx_t CFG_VALUE_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    ST_REPLAYED   = 3'd0,
    ST_CRC_BAD    = 3'd1,
    ST_TOO_LONG   = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_MID_RECORD = 3'd4,
    ST_HALTED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  // one result word before the store read data is attached
  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [7:0]  rtype;
    logic [7:0]  klen;
    logic [9:0]  vlen;
    logic [15:0] count;
    logic        done;
    logic        in_range;
  } res_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_table_gen();
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_table_gen();

  // reflected crc32c, one byte per call
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ CRC_TABLE[crc[7:0] ^ b];
  endfunction

endpackage

>>> sv/lrc_in_if.sv
// ---------------------------------------------------------------------------
// lrc_in_if
// Input channel: log bytes and store read requests.
// ---------------------------------------------------------------------------
interface lrc_in_if;
  import lrc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [7:0]            log_byte;
  logic                  end_of_log;
  logic [READ_IDX_W-1:0] read_index;

  modport source(output valid, output opcode, output log_byte, output end_of_log,
                 output read_index, input ready);
  modport sink(input valid, input opcode, input log_byte, input end_of_log,
               input read_index, output ready);
endinterface

>>> sv/lrc_out_if.sv
// ---------------------------------------------------------------------------
// lrc_out_if
// Result channel: record events, end events and store read data.
// ---------------------------------------------------------------------------
interface lrc_out_if;
  import lrc_pkg::*;

  logic        valid;
  logic        ready;
  logic        result_kind;
  status_t     status;
  logic [7:0]  record_type;
  logic [7:0]  key_length;
  logic [9:0]  value_length;
  logic [15:0] replayed_count;
  logic        log_done;
  logic [7:0]  read_data;

  modport source(output valid, output result_kind, output status, output record_type,
                 output key_length, output value_length, output replayed_count,
                 output log_done, output read_data, input ready);
  modport sink(input valid, input result_kind, input status, input record_type,
               input key_length, input value_length, input replayed_count,
               input log_done, input read_data, output ready);
endinterface

>>> sv/lrc_store.sv
// ---------------------------------------------------------------------------
// lrc_store
// Payload byte store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module lrc_store #(
  parameter int DEPTH  = lrc_pkg::PAYLOAD_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data only moves on a new request, so a stalled read word keeps it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/lrc_parser.sv
// ---------------------------------------------------------------------------
// lrc_parser
// Record framing, CRC32C, length checks and result decision per word.
// ---------------------------------------------------------------------------
module lrc_parser #(
  parameter int DEPTH  = lrc_pkg::PAYLOAD_DEPTH_DEF,
  parameter int POS_W  = $clog2(DEPTH + 1),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic                              opcode,
  input  logic [7:0]                        log_byte,
  input  logic                              end_of_log,
  input  logic [lrc_pkg::READ_IDX_W-1:0]    read_index,
  input  logic                              cfg_we,
  input  lrc_pkg::cfg_idx_t                 cfg_index,
  input  logic [lrc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              res_valid,
  output lrc_pkg::res_t                     res,
  output logic                              wr_en,
  output logic [ADDR_W-1:0]                 wr_addr,
  output logic [7:0]                        wr_data,
  output logic                              rd_en,
  output logic [ADDR_W-1:0]                 rd_addr
);
  import lrc_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [31:0]          crc_r, crc_nxt;
  logic [31:0]          exp_r, exp_nxt;
  logic [23:0]          lenlo_r, lenlo_nxt;
  logic [POS_W-1:0]     len_r, len_nxt;
  logic [31:0]          klen_r, klen_nxt;
  logic [31:0]          vlen_r, vlen_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [15:0]          count_r, count_nxt;
  logic [KEY_LIM_W-1:0] klim_r, klim_nxt;
  logic [VAL_LIM_W-1:0] vlim_r, vlim_nxt;

  logic             feed;
  logic             done;
  logic             to_payload;
  status_t          st;
  logic [31:0]      full_len;
  logic [POS_W-1:0] pos_inc;
  logic [31:0]      crc_upd, exp_upd, klen_upd, vlen_upd;
  logic [23:0]      lenlo_upd;
  logic [7:0]       type_upd;
  logic [1:0]       lane;
  logic [3:0]       hp;
  logic [32:0]      kv_sum;
  logic [32:0]      body;
  logic [31:0]      idx_ext;

  assign feed     = accept && !opcode;
  assign full_len = {log_byte, lenlo_r};
  assign pos_inc  = pos_r + POS_W'(1);
  assign hp       = pos_r[3:0];
  assign idx_ext  = 32'(read_index);

  // decode one log byte against the current phase
  always_comb begin
    crc_upd    = crc_r;
    exp_upd    = exp_r;
    lenlo_upd  = lenlo_r;
    klen_upd   = klen_r;
    vlen_upd   = vlen_r;
    type_upd   = type_r;
    done       = 1'b0;
    to_payload = 1'b0;
    st         = ST_REPLAYED;
    lane       = 2'd0;
    kv_sum     = 33'd0;
    body       = 33'd0;
    unique case (phase_r)
      PH_HEADER: begin
        lane = pos_r[1:0];
        if (!pos_r[2]) begin
          exp_upd[{lane, 3'b000} +: 8] = log_byte;
        end else if (pos_r[2:0] != 3'd7) begin
          lenlo_upd[{lane, 3'b000} +: 8] = log_byte;
        end else if (full_len > 32'(DEPTH)) begin
          done = 1'b1;
          st   = ST_TOO_LONG;
        end else if (full_len == 32'd0) begin
          // crc of nothing is zero; an empty payload cannot hold the header
          done = 1'b1;
          st   = (exp_r != 32'd0) ? ST_CRC_BAD : ST_BAD_LENGTH;
        end else begin
          to_payload = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        crc_upd = crc_update(crc_r, log_byte);
        if (pos_r < POS_W'(HDR_BYTES)) begin
          if (hp == 4'd0) begin
            type_upd = log_byte;
          end else if (hp <= 4'd4) begin
            lane = 2'(hp - 4'd1);
            klen_upd[{lane, 3'b000} +: 8] = log_byte;
          end else begin
            lane = 2'(hp - 4'd5);
            vlen_upd[{lane, 3'b000} +: 8] = log_byte;
          end
        end
        kv_sum = {1'b0, klen_upd} + {1'b0, vlen_upd};
        body   = 33'(len_r) - 33'(HDR_BYTES);
        if (pos_inc >= len_r) begin
          done = 1'b1;
          if ((crc_upd ^ CRC_ONES) != exp_r) begin
            st = ST_CRC_BAD;
          end else if (len_r < POS_W'(HDR_BYTES)) begin
            st = ST_BAD_LENGTH;
          end else if (kv_sum > body) begin
            st = ST_BAD_LENGTH;
          end else if (klen_upd > 32'(klim_r)) begin
            st = ST_BAD_LENGTH;
          end else if (vlen_upd > 32'(vlim_r)) begin
            st = ST_BAD_LENGTH;
          end else begin
            st = ST_REPLAYED;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    exp_nxt   = exp_r;
    lenlo_nxt = lenlo_r;
    len_nxt   = len_r;
    klen_nxt  = klen_r;
    vlen_nxt  = vlen_r;
    type_nxt  = type_r;
    count_nxt = count_r;
    klim_nxt  = klim_r;
    vlim_nxt  = vlim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LIMIT:   klim_nxt = cfg_wdata[KEY_LIM_W-1:0];
        CFG_VALUE_LIMIT: vlim_nxt = cfg_wdata[VAL_LIM_W-1:0];
        default: ;
      endcase
    end
    if (feed && (phase_r == PH_HEADER || phase_r == PH_PAYLOAD)) begin
      crc_nxt   = crc_upd;
      exp_nxt   = exp_upd;
      lenlo_nxt = lenlo_upd;
      klen_nxt  = klen_upd;
      vlen_nxt  = vlen_upd;
      type_nxt  = type_upd;
      pos_nxt   = pos_inc;
      if (to_payload) begin
        phase_nxt = PH_PAYLOAD;
        pos_nxt   = '0;
        len_nxt   = full_len[POS_W-1:0];
      end
      if (done && st == ST_REPLAYED) begin
        if (count_r != CNT_MAX) begin
          count_nxt = count_r + 16'd1;
        end
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        crc_nxt   = CRC_ONES;
        exp_nxt   = '0;
        lenlo_nxt = '0;
        klen_nxt  = '0;
        vlen_nxt  = '0;
        type_nxt  = '0;
      end
      if ((done && st != ST_REPLAYED) || end_of_log) begin
        phase_nxt = PH_HALTED;
      end
    end
  end

  // result word and store requests
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    wr_en     = feed && (phase_r == PH_PAYLOAD);
    wr_addr   = pos_r[ADDR_W-1:0];
    wr_data   = log_byte;
    rd_en     = accept && opcode;
    rd_addr   = idx_ext[ADDR_W-1:0];
    if (accept && opcode) begin
      res_valid    = 1'b1;
      res.kind     = 1'b1;
      res.status   = ST_REPLAYED;
      res.in_range = idx_ext < 32'(DEPTH);
    end else if (feed) begin
      res.count  = count_nxt;
      res.status = st;
      if (phase_r != PH_HEADER && phase_r != PH_PAYLOAD) begin
        res_valid  = 1'b1;
        res.status = ST_HALTED;
      end else if (done) begin
        res_valid = 1'b1;
        res.rtype = type_upd;
        res.done  = end_of_log;
        if (st == ST_REPLAYED) begin
          res.klen = klen_upd[7:0];
          res.vlen = vlen_upd[9:0];
        end
      end else if (end_of_log) begin
        res_valid  = 1'b1;
        res.status = ST_MID_RECORD;
        res.done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      crc_r   <= CRC_ONES;
      exp_r   <= '0;
      lenlo_r <= '0;
      len_r   <= '0;
      klen_r  <= '0;
      vlen_r  <= '0;
      type_r  <= '0;
      count_r <= '0;
      klim_r  <= KEY_LIM_RST;
      vlim_r  <= VAL_LIM_RST;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      exp_r   <= exp_nxt;
      lenlo_r <= lenlo_nxt;
      len_r   <= len_nxt;
      klen_r  <= klen_nxt;
      vlen_r  <= vlen_nxt;
      type_r  <= type_nxt;
      count_r <= count_nxt;
      klim_r  <= klim_nxt;
      vlim_r  <= vlim_nxt;
    end
  end

endmodule

>>> sv/log_record_checker_crc32c.sv
// ---------------------------------------------------------------------------
// log_record_checker_crc32c
// Deframes CRC32C length-prefixed log records, stores payloads, checks them.
// ---------------------------------------------------------------------------
//  port       dir   handshake        contents
//  in_ch      in    valid/ready      opcode, log_byte, end_of_log, read_index
//  out_ch     out   valid/ready      record/end event or stored payload byte
//  cfg_*      in    write enable     key and value length limits
//
//  one input word per cycle unless the output stalls; each result is held
//  in a stage register beside the store's registered read port, then in
//  the output register. a stalled output holds its word; one more result
//  waits in the stage before it, so input stops only when both are full.
//  reset clears framing and counters, sets default limits; store not cleared.
// ---------------------------------------------------------------------------
module log_record_checker_crc32c #(
  parameter int PAYLOAD_DEPTH = lrc_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lrc_in_if.sink                         in_ch,
  lrc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  lrc_pkg::cfg_idx_t              cfg_index,
  input  logic [lrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lrc_pkg::*;

  localparam int POS_W  = $clog2(PAYLOAD_DEPTH + 1);
  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

  logic              accept;
  logic              res_valid;
  res_t              res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  logic       s1_valid_r, s1_valid_nxt;
  res_t       s1_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_r;
  logic [7:0] out_rdata_r;
  logic       s1_adv;

  assign in_ch.ready = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);

  lrc_parser #(
    .DEPTH  (PAYLOAD_DEPTH),
    .POS_W  (POS_W),
    .ADDR_W (ADDR_W)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_ch.opcode),
    .log_byte   (in_ch.log_byte),
    .end_of_log (in_ch.end_of_log),
    .read_index (in_ch.read_index),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .res_valid  (res_valid),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  lrc_store #(
    .DEPTH  (PAYLOAD_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = res_valid;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
    if (s1_adv) begin
      out_r       <= s1_r;
      out_rdata_r <= (s1_r.kind && s1_r.in_range) ? rd_data : 8'd0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_r.kind;
  assign out_ch.status         = out_r.status;
  assign out_ch.record_type    = out_r.rtype;
  assign out_ch.key_length     = out_r.klen;
  assign out_ch.value_length   = out_r.vlen;
  assign out_ch.replayed_count = out_r.count;
  assign out_ch.log_done       = out_r.done;
  assign out_ch.read_data      = out_rdata_r;

endmodule

>>> sv/lrc_checker.sv
// ---------------------------------------------------------------------------
// lrc_checker
// Port-level checks on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
module lrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [2:0]  status,
  input logic [7:0]  record_type,
  input logic [7:0]  key_length,
  input logic [9:0]  value_length,
  input logic [15:0] replayed_count,
  input logic        log_done,
  input logic [7:0]  read_data
);
  import lrc_pkg::*;

  logic        ev_acc;
  logic        ended_r, ended_nxt;
  logic [15:0] last_cnt_r, last_cnt_nxt;

  assign ev_acc = out_valid && out_ready && !result_kind;

  always_comb begin
    ended_nxt    = ended_r;
    last_cnt_nxt = last_cnt_r;
    if (ev_acc) begin
      last_cnt_nxt = replayed_count;
      if (log_done) begin
        ended_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r    <= 1'b0;
      last_cnt_r <= '0;
    end else begin
      ended_r    <= ended_nxt;
      last_cnt_r <= last_cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(status)
      && $stable(record_type) && $stable(key_length) && $stable(value_length)
      && $stable(replayed_count) && $stable(log_done) && $stable(read_data))
    else $error("result word changed while stalled");

  a_halt_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    ev_acc && ended_r |-> status == ST_HALTED)
    else $error("log byte after end of log was not reported halted");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ev_acc |-> replayed_count >= last_cnt_r)
    else $error("replayed count went backwards");

  a_replay_step: assert property (@(posedge clk) disable iff (!rst_n)
    ev_acc && status == ST_REPLAYED |->
      (replayed_count == last_cnt_r + 16'd1) ||
      (last_cnt_r == CNT_MAX && replayed_count == CNT_MAX))
    else $error("replay did not advance the count by one");

endmodule

bind log_record_checker_crc32c lrc_checker u_lrc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .result_kind    (out_ch.result_kind),
  .status         (out_ch.status),
  .record_type    (out_ch.record_type),
  .key_length     (out_ch.key_length),
  .value_length   (out_ch.value_length),
  .replayed_count (out_ch.replayed_count),
  .log_done       (out_ch.log_done),
  .read_data      (out_ch.read_data)
);

>>> dv/lrc_tb_pkg.sv
// ---------------------------------------------------------------------------
// lrc_tb_pkg
// Scoreboard for the log record checker: keeps its own model of the
// deframer, predicts the result word of each accepted input word and
// matches the result words in order.
// ---------------------------------------------------------------------------
package lrc_tb_pkg;
  import lrc_pkg::*;

  typedef bit [7:0] octet_q[$];

  typedef struct {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  rtype;
    logic [7:0]  klen;
    logic [9:0]  vlen;
    logic [15:0] count;
    logic        done;
    logic [7:0]  rdata;
  } event_word_t;

  // reflected crc32c, one bit at a time
  function automatic bit [31:0] crc32c_shift(bit [31:0] crc, bit [7:0] b);
    bit [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  class deframer_scoreboard;
    bit [KEY_LIM_W-1:0] key_lim;
    bit [VAL_LIM_W-1:0] val_lim;

    phase_t      phase;
    bit [11:0]   pos;
    bit [31:0]   crc;
    bit [31:0]   crc_field;
    bit [31:0]   plen;
    bit [31:0]   klen;
    bit [31:0]   vlen;
    bit [7:0]    rtype;
    bit [7:0]    store [PAYLOAD_DEPTH_DEF];
    int          store_fill;
    bit [15:0]   replays;

    event_word_t awaited[$];
    int          errors;

    function new();
      key_lim    = KEY_LIM_RST;
      val_lim    = VAL_LIM_RST;
      replays    = 16'h0;
      store_fill = 0;
      errors     = 0;
      open_record();
    endfunction

    function void open_record();
      phase     = PH_HEADER;
      pos       = 12'h0;
      crc       = CRC_ONES;
      crc_field = 32'h0;
      plen      = 32'h0;
      klen      = 32'h0;
      vlen      = 32'h0;
      rtype     = 8'h0;
    endfunction

    function void set_limit(cfg_idx_t idx, bit [CFG_DATA_W-1:0] data);
      if (idx == CFG_KEY_LIMIT) begin
        key_lim = data[KEY_LIM_W-1:0];
      end else begin
        val_lim = data[VAL_LIM_W-1:0];
      end
    endfunction

    // crc first, then the length checks
    function status_t judge();
      bit [33:0] room;
      if ((crc ^ CRC_ONES) != crc_field) return ST_CRC_BAD;
      if (plen < HDR_BYTES) return ST_BAD_LENGTH;
      room = {2'b00, plen} - 34'(HDR_BYTES);
      if ({2'b00, klen} + {2'b00, vlen} > room) return ST_BAD_LENGTH;
      if (klen > key_lim) return ST_BAD_LENGTH;
      if (vlen > val_lim) return ST_BAD_LENGTH;
      return ST_REPLAYED;
    endfunction

    function void note_input(bit op, bit [7:0] b, bit eol, bit [READ_IDX_W-1:0] idx);
      event_word_t w;
      bit          fin;
      status_t     st;
      bit [2:0]    p;
      w   = '{default: '0};
      fin = 1'b0;
      st  = ST_REPLAYED;
      if (op) begin
        w.kind  = 1'b1;
        w.rdata = (idx < PAYLOAD_DEPTH_DEF) ? store[idx] : 8'h00;
        awaited.push_back(w);
        return;
      end
      if (phase != PH_HEADER && phase != PH_PAYLOAD) begin
        w.status = ST_HALTED;
        w.count  = replays;
        awaited.push_back(w);
        return;
      end
      if (phase == PH_HEADER) begin
        p = pos[2:0];
        if (p < 4) crc_field |= 32'(b) << (8 * p);
        else plen |= 32'(b) << (8 * (p - 4));
        pos = 12'(p) + 12'd1;
        if (pos == 12'd8) begin
          if (plen > PAYLOAD_DEPTH_DEF) begin
            fin = 1'b1;
            st  = ST_TOO_LONG;
          end else if (plen == 0) begin
            fin = 1'b1;
            st  = judge();
          end else begin
            phase = PH_PAYLOAD;
            pos   = 12'h0;
          end
        end
      end else begin
        if (pos < PAYLOAD_DEPTH_DEF) begin
          store[pos] = b;
          if (int'(pos) >= store_fill) store_fill = int'(pos) + 1;
        end
        crc = crc32c_shift(crc, b);
        if (pos == 0) rtype = b;
        else if (pos <= 4) klen |= 32'(b) << (8 * (pos - 1));
        else if (pos <= 8) vlen |= 32'(b) << (8 * (pos - 5));
        pos = pos + 12'd1;
        if (32'(pos) >= plen) begin
          fin = 1'b1;
          st  = judge();
        end
      end
      if (fin) begin
        w.rtype = rtype;
        if (st == ST_REPLAYED) begin
          w.klen = klen[7:0];
          w.vlen = vlen[9:0];
          if (replays != CNT_MAX) replays++;
          open_record();
        end else begin
          phase = PH_HALTED;
        end
      end else if (eol) begin
        st = ST_MID_RECORD;
      end
      // quiet byte
      if (!fin && !eol) return;
      if (eol) phase = PH_HALTED;
      w.status = st;
      w.count  = replays;
      w.done   = eol;
      awaited.push_back(w);
    endfunction

    function string show(event_word_t w);
      return $sformatf("kind=%0d status=%0d type=%02h klen=%0d vlen=%0d count=%0d done=%0d data=%02h",
                       w.kind, w.status, w.rtype, w.klen, w.vlen, w.count, w.done, w.rdata);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t %s", $time, msg);
    endfunction

    function void match_result(event_word_t got);
      event_word_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result word with none awaited: %s", show(got)));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.status !== want.status || got.rtype !== want.rtype ||
          got.klen !== want.klen || got.vlen !== want.vlen || got.count !== want.count ||
          got.done !== want.done || got.rdata !== want.rdata) begin
        flag($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
      end
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives log records and store reads into the record checker under several
// limit settings and idle patterns, ends the log with one randomly chosen
// failure or end case, and checks every result word against the scoreboard.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lrc_pkg::*;
  import lrc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 180;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lrc_in_if  in_if();
  lrc_out_if out_if();

  deframer_scoreboard sb;
  int src_idle   = 0;
  int sink_stall = 0;
  int words_sent = 0;
  int cycles     = 0;

  log_record_checker_crc32c uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : rx
    event_word_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind   = out_if.result_kind;
      got.status = out_if.status;
      got.rtype  = out_if.record_type;
      got.klen   = out_if.key_length;
      got.vlen   = out_if.value_length;
      got.count  = out_if.replayed_count;
      got.done   = out_if.log_done;
      got.rdata  = out_if.read_data;
      sb.match_result(got);
    end
    out_if.ready <= ($urandom_range(0, 99) >= sink_stall);
  end

  task automatic send_word(bit op, bit [7:0] b, bit eol, bit [READ_IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.log_byte   <= b;
    in_if.end_of_log <= eol;
    in_if.read_index <= idx;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, b, eol, idx);
    words_sent++;
  endtask

  // only entries already written are read back
  task automatic send_read();
    send_word(1'b1, 8'($urandom()), 1'($urandom()),
              READ_IDX_W'($urandom_range(0, sb.store_fill - 1)));
  endtask

  task automatic send_log(octet_q q, int eol_at);
    foreach (q[i]) begin
      if (sb.store_fill > 0 && $urandom_range(0, 9) == 0) send_read();
      send_word(1'b0, q[i], i == eol_at, READ_IDX_W'($urandom_range(0, 2047)));
    end
  endtask

  function automatic octet_q header(bit [31:0] c, bit [31:0] n);
    octet_q q;
    for (int i = 0; i < 4; i++) q.push_back(c[8*i +: 8]);
    for (int i = 0; i < 4; i++) q.push_back(n[8*i +: 8]);
    return q;
  endfunction

  function automatic octet_q record_body(bit [7:0] rt, bit [31:0] k, bit [31:0] v, int rest);
    octet_q q;
    q.push_back(rt);
    for (int i = 0; i < 4; i++) q.push_back(k[8*i +: 8]);
    for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
    repeat (rest) q.push_back(8'($urandom()));
    return q;
  endfunction

  function automatic octet_q good_body();
    int kmax;
    int vmax;
    int k;
    int v;
    int x;
    bit big;
    big  = ($urandom_range(0, 15) == 0);
    kmax = (big || sb.key_lim < 24) ? int'(sb.key_lim) : 24;
    vmax = big ? ((sb.val_lim < 400) ? int'(sb.val_lim) : 400)
               : ((sb.val_lim < 24) ? int'(sb.val_lim) : 24);
    k = $urandom_range(0, kmax);
    v = $urandom_range(0, vmax);
    // lengths right at the limits now and then
    if ($urandom_range(0, 7) == 0) begin
      k = kmax;
      v = vmax;
    end
    x = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
    return record_body(8'($urandom()), k, v, k + v + x);
  endfunction

  task automatic send_framed(octet_q body, bit crc_bad, int eol_at);
    octet_q q;
    bit [31:0] c;
    c = CRC_ONES;
    foreach (body[i]) c = crc32c_shift(c, body[i]);
    c = c ^ CRC_ONES;
    if (crc_bad) c = c ^ (32'h1 << $urandom_range(0, 31));
    q = header(c, body.size());
    foreach (body[i]) q.push_back(body[i]);
    send_log(q, eol_at);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limits(int klim, int vlim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_LIMIT;
    cfg_wdata <= {2'($urandom()), 8'(klim)};
    @(posedge clk);
    sb.set_limit(CFG_KEY_LIMIT, CFG_DATA_W'(klim));
    cfg_index <= CFG_VALUE_LIMIT;
    cfg_wdata <= CFG_DATA_W'(vlim);
    @(posedge clk);
    sb.set_limit(CFG_VALUE_LIMIT, CFG_DATA_W'(vlim));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int klim, int vlim, int src_pct, int sink_pct);
    int start;
    settle();
    write_limits(klim, vlim);
    src_idle   = src_pct;
    sink_stall = sink_pct;
    start      = words_sent;
    while (words_sent - start < PHASE_WORDS) send_framed(good_body(), 1'b0, -1);
  endtask

  // the log ends in one way per run, since only reset clears the halt
  task automatic close_log();
    octet_q    body;
    bit [31:0] n;
    bit [7:0]  rt;
    int        k;
    int        v;
    rt = 8'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        body = good_body();
        send_framed(body, 1'b0, body.size() + 7);
      end
      1: send_framed(good_body(), 1'b1, -1);
      2: begin
        case ($urandom_range(0, 2))
          0: n = 32'd2049;
          1: n = 32'hFFFF_FFFF;
          default: begin
            n = $urandom();
            if (n <= 2048) n = n + 32'd2049;
          end
        endcase
        send_log(header($urandom(), n), -1);
      end
      3: send_log(header($urandom_range(0, 1) ? 32'h0 : 32'($urandom()), 32'h0), -1);
      4: begin
        repeat ($urandom_range(1, 8)) body.push_back(8'($urandom()));
        send_framed(body, 1'b0, -1);
      end
      5: begin
        if ($urandom_range(0, 1)) begin
          k = $urandom_range(1, 20);
          v = $urandom_range(0, 20);
          body = record_body(rt, k, v, k + v - 1);
        end else begin
          body = record_body(rt, 32'hFFFF_FFFF, 32'd2, 4);
        end
        send_framed(body, 1'b0, -1);
      end
      6: begin
        k = int'(sb.key_lim) + 1;
        v = $urandom_range(0, (sb.val_lim < 8) ? int'(sb.val_lim) : 8);
        send_framed(record_body(rt, k, v, k + v + $urandom_range(0, 2)), 1'b0, -1);
      end
      7: begin
        v = int'(sb.val_lim) + 1;
        k = $urandom_range(0, (sb.key_lim < 8) ? int'(sb.key_lim) : 8);
        send_framed(record_body(rt, k, v, k + v + $urandom_range(0, 2)), 1'b0, -1);
      end
      8: send_framed(good_body(), 1'b0, $urandom_range(0, 7));
      default: begin
        body = good_body();
        send_framed(body, 1'b0, 8 + $urandom_range(0, body.size() - 2));
      end
    endcase
  endtask

  initial begin
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_KEY_LIMIT;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= 1'b0;
    in_if.log_byte    <= 8'h0;
    in_if.end_of_log  <= 1'b0;
    in_if.read_index  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shortest legal payload at reset limits, then read back its ends
    send_framed(record_body(8'hFF, 32'h0, 32'h0, 0), 1'b0, -1);
    send_word(1'b1, 8'h00, 1'b0, READ_IDX_W'(0));
    send_word(1'b1, 8'hFF, 1'b1, READ_IDX_W'(8));

    run_phase(KEY_LIM_RST, VAL_LIM_RST, 0, 0);
    run_phase(0, 0, 85, 0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 1023), 0, 85);
    run_phase(0, 1023, 34, 34);
    run_phase(255, 0, 0, 0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 1023), 85, 0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 1023), 34, 34);
    run_phase($urandom_range(0, 255), $urandom_range(0, 1023), 0, 85);

    settle();
    write_limits($urandom_range(0, 255), $urandom_range(0, 1023));
    src_idle   = 34;
    sink_stall = 34;
    repeat ($urandom_range(1, 4)) send_framed(good_body(), 1'b0, -1);
    close_log();
    // halted: log words answer with the halt status, reads still work
    repeat (24) begin
      if (sb.store_fill > 0 && $urandom_range(0, 2) == 0) send_read();
      else send_word(1'b0, 8'($urandom()), 1'($urandom()), READ_IDX_W'($urandom_range(0, 2047)));
    end
    settle();

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lrc_pkg.sv
sv/lrc_in_if.sv
sv/lrc_out_if.sv
sv/lrc_store.sv
sv/lrc_parser.sv
sv/log_record_checker_crc32c.sv
sv/lrc_checker.sv
dv/lrc_tb_pkg.sv
dv/tb_top.sv
